// ===== rtl/letterbox_touch_coordinate_mapper_defines.svh =====
// Assertion macros shared by the letterbox touch mapper RTL.
// Used by files that carry concurrent checks; relies on i_clk and i_rst_n in scope.
`ifndef LETTERBOX_TOUCH_COORDINATE_MAPPER_DEFINES_SVH
`define LETTERBOX_TOUCH_COORDINATE_MAPPER_DEFINES_SVH

// Same-cycle implication check, disabled during reset.
`define LTCM_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("letterbox mapper check failed");

// Next-cycle implication check, disabled during reset.
`define LTCM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("letterbox mapper check failed");

`endif

// ===== rtl/ltcm_pkg.sv =====
// Shared types and codes for the letterbox touch coordinate mapper.
// No dependencies.
package ltcm_pkg;

    typedef logic [63:0] t_word;

    typedef struct packed {
        logic [12:0] disp_w;
        logic [12:0] disp_h;
        logic [12:0] vis_w;
        logic [12:0] vis_h;
        logic [12:0] nav_t;
        logic [1:0]  nav_e;
        logic [15:0] tmax_x;
        logic [15:0] tmax_y;
    } t_cfg;

    localparam logic [2:0] REG_DISP_W = 3'd0;
    localparam logic [2:0] REG_DISP_H = 3'd1;
    localparam logic [2:0] REG_VIS_W  = 3'd2;
    localparam logic [2:0] REG_VIS_H  = 3'd3;
    localparam logic [2:0] REG_NAV_T  = 3'd4;
    localparam logic [2:0] REG_NAV_E  = 3'd5;
    localparam logic [2:0] REG_TMAX_X = 3'd6;
    localparam logic [2:0] REG_TMAX_Y = 3'd7;

    localparam logic [1:0] EDGE_TOP    = 2'd0;
    localparam logic [1:0] EDGE_BOTTOM = 2'd1;
    localparam logic [1:0] EDGE_LEFT   = 2'd2;
    localparam logic [1:0] EDGE_RIGHT  = 2'd3;

    localparam logic OP_DIV = 1'b0;
    localparam logic OP_MUL = 1'b1;

endpackage

// ===== rtl/ltcm_serial.sv =====
// Bit-serial 64-bit unit: restoring divide or shift-add multiply with Q rescale.
// Depends on ltcm_pkg.
module ltcm_serial import ltcm_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_op,
    input  t_word i_a,
    input  t_word i_b,
    output logic  o_done,
    output t_word o_res
);
    logic [5:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic         r_op;
    t_word        r_a;
    t_word        r_b;
    logic [127:0] r_acc;
    t_word        r_q;

    logic [64:0]  rem2;
    logic         ge;
    logic [64:0]  rem_sub;

    always_comb begin
        rem2    = {r_acc[63:0], r_a[63]};
        ge      = rem2 >= {1'b0, r_b};
        rem_sub = rem2 - {1'b0, r_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= i_op;
            r_a    <= i_a;
            r_b    <= i_b;
            r_acc  <= '0;
            r_q    <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                if (r_op == OP_DIV) begin
                    r_acc <= {64'd0, ge ? rem_sub[63:0] : rem2[63:0]};
                    r_q   <= {r_q[62:0], ge};
                    r_a   <= {r_a[62:0], 1'b0};
                end else begin
                    r_acc <= {r_acc[126:0], 1'b0} + (r_b[63] ? {64'd0, r_a} : 128'd0);
                    r_b   <= {r_b[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_op == OP_DIV) ? r_q : r_acc[FRAC_BITS +: 64];
endmodule

// ===== rtl/ltcm_setup.sv =====
// Derives touch-space origins and spans of the fitted region from the registers.
// Depends on ltcm_pkg and ltcm_serial.
module ltcm_setup import ltcm_pkg::*; #(
    parameter int FRAC_BITS = 16,
    localparam int OXW = 17 + FRAC_BITS,
    localparam int SXW = 18 + FRAC_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cfg           i_cfg,
    input  logic           i_cfg_wr,
    output logic           o_ready,
    output logic [OXW-1:0] o_ox,
    output logic [OXW-1:0] o_oy,
    output logic [SXW-1:0] o_sx,
    output logic [SXW-1:0] o_sy
);
    localparam logic [3:0] ST_UPPX = 4'd0;
    localparam logic [3:0] ST_UPPY = 4'd1;
    localparam logic [3:0] ST_CASP = 4'd2;
    localparam logic [3:0] ST_DASP = 4'd3;
    localparam logic [3:0] ST_RH   = 4'd4;
    localparam logic [3:0] ST_OX   = 4'd5;
    localparam logic [3:0] ST_OY   = 4'd6;
    localparam logic [3:0] ST_SX   = 4'd7;
    localparam logic [3:0] ST_SY   = 4'd8;
    localparam logic [3:0] ST_IDLE = 4'd9;

    logic [3:0] r_state;
    logic       r_run;
    t_word      r_uppx, r_uppy, r_casp, r_dasp, r_rw, r_rh;
    logic       r_fillw;
    logic [OXW-1:0] r_ox, r_oy;
    logic [SXW-1:0] r_sx, r_sy;

    t_word dw, dh, ew, eh, px0, py0, vw1, vh1, tmx, tmy, rx0, ry0, op_a, op_b, res, res1;
    logic  op, start, done;

    always_comb begin
        dw  = (i_cfg.disp_w == 13'd0) ? 64'd1 : {51'd0, i_cfg.disp_w};
        dh  = (i_cfg.disp_h == 13'd0) ? 64'd1 : {51'd0, i_cfg.disp_h};
        vw1 = (i_cfg.vis_w == 13'd0) ? 64'd1 : {51'd0, i_cfg.vis_w};
        vh1 = (i_cfg.vis_h == 13'd0) ? 64'd1 : {51'd0, i_cfg.vis_h};
        tmx = (i_cfg.tmax_x == 16'd0) ? 64'd1 : {48'd0, i_cfg.tmax_x};
        tmy = (i_cfg.tmax_y == 16'd0) ? 64'd1 : {48'd0, i_cfg.tmax_y};
        ew  = dw;
        eh  = dh;
        px0 = '0;
        py0 = '0;
        if (i_cfg.nav_t != 13'd0) begin
            if (i_cfg.nav_e == EDGE_TOP || i_cfg.nav_e == EDGE_BOTTOM) begin
                eh = (dh > {51'd0, i_cfg.nav_t}) ? dh - {51'd0, i_cfg.nav_t} : 64'd1;
                if (i_cfg.nav_e == EDGE_TOP) py0 = {51'd0, i_cfg.nav_t};
            end else begin
                ew = (dw > {51'd0, i_cfg.nav_t}) ? dw - {51'd0, i_cfg.nav_t} : 64'd1;
                if (i_cfg.nav_e == EDGE_LEFT) px0 = {51'd0, i_cfg.nav_t};
            end
        end
        if (r_fillw) begin
            rx0 = px0 << FRAC_BITS;
            ry0 = (py0 << FRAC_BITS) + (((eh << FRAC_BITS) - r_rh) >> 1);
        end else begin
            ry0 = py0 << FRAC_BITS;
            rx0 = (px0 << FRAC_BITS) + (((ew << FRAC_BITS) - r_rw) >> 1);
        end
    end

    always_comb begin
        op   = OP_DIV;
        op_a = '0;
        op_b = 64'd1;
        unique case (r_state)
            ST_UPPX: begin op_a = tmx << FRAC_BITS; op_b = dw; end
            ST_UPPY: begin op_a = tmy << FRAC_BITS; op_b = dh; end
            ST_CASP: begin op_a = vw1 << FRAC_BITS; op_b = vh1; end
            ST_DASP: begin op_a = ew << FRAC_BITS; op_b = eh; end
            ST_RH: begin
                if (r_casp > r_dasp) begin
                    op_a = ew << (2 * FRAC_BITS);
                    op_b = r_casp;
                end else begin
                    op   = OP_MUL;
                    op_a = eh << FRAC_BITS;
                    op_b = r_casp;
                end
            end
            ST_OX:   begin op = OP_MUL; op_a = rx0;  op_b = r_uppx; end
            ST_OY:   begin op = OP_MUL; op_a = ry0;  op_b = r_uppy; end
            ST_SX:   begin op = OP_MUL; op_a = r_rw; op_b = r_uppx; end
            ST_SY:   begin op = OP_MUL; op_a = r_rh; op_b = r_uppy; end
            default: begin op = OP_DIV; end
        endcase
    end

    assign start = (r_state != ST_IDLE) && !r_run && !i_cfg_wr;

    ltcm_serial #(.FRAC_BITS(FRAC_BITS)) u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (op),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_done  (done),
        .o_res   (res)
    );

    // Spans that truncate to zero count as one Q step.
    assign res1 = (res == 64'd0) ? 64'd1 : res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_UPPX;
            r_run   <= 1'b0;
        end else if (i_cfg_wr) begin
            r_state <= ST_UPPX;
            r_run   <= 1'b0;
        end else if (r_state != ST_IDLE) begin
            if (!r_run) begin
                r_run <= 1'b1;
            end else if (done) begin
                r_run <= 1'b0;
                unique case (r_state)
                    ST_UPPX: begin r_uppx <= res; r_state <= ST_UPPY; end
                    ST_UPPY: begin r_uppy <= res; r_state <= ST_CASP; end
                    ST_CASP: begin r_casp <= res; r_state <= ST_DASP; end
                    ST_DASP: begin r_dasp <= res; r_state <= ST_RH; end
                    ST_RH: begin
                        r_fillw <= r_casp > r_dasp;
                        if (r_casp > r_dasp) begin
                            r_rh <= res;
                            r_rw <= ew << FRAC_BITS;
                        end else begin
                            r_rw <= res;
                            r_rh <= eh << FRAC_BITS;
                        end
                        r_state <= ST_OX;
                    end
                    ST_OX: begin
                        r_ox <= ((res >> OXW) != 64'd0) ? '1 : res[OXW-1:0];
                        r_state <= ST_OY;
                    end
                    ST_OY: begin
                        r_oy <= ((res >> OXW) != 64'd0) ? '1 : res[OXW-1:0];
                        r_state <= ST_SX;
                    end
                    ST_SX: begin
                        r_sx <= ((res1 >> SXW) != 64'd0) ? '1 : res1[SXW-1:0];
                        r_state <= ST_SY;
                    end
                    ST_SY: begin
                        r_sy <= ((res1 >> SXW) != 64'd0) ? '1 : res1[SXW-1:0];
                        r_state <= ST_IDLE;
                    end
                    default: r_state <= ST_IDLE;
                endcase
            end
        end
    end

    assign o_ready = (r_state == ST_IDLE) && !i_cfg_wr;
    assign o_ox = r_ox;
    assign o_oy = r_oy;
    assign o_sx = r_sx;
    assign o_sy = r_sy;
endmodule

// ===== rtl/ltcm_axis.sv =====
// Per-axis pipeline: clamp against the region, one quotient bit per stage, scale.
// Depends on ltcm_pkg.
module ltcm_axis import ltcm_pkg::*; #(
    parameter int FRAC_BITS = 16,
    localparam int OXW = 17 + FRAC_BITS,
    localparam int SXW = 18 + FRAC_BITS
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [15:0]    i_raw,
    input  logic [OXW-1:0] i_ox,
    input  logic [SXW-1:0] i_sx,
    input  logic [12:0]    i_vis,
    output logic [12:0]    o_mapped
);
    logic [SXW-1:0]       r_rem  [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] r_q    [0:FRAC_BITS];
    logic                 r_zero [0:FRAC_BITS];
    logic                 r_one  [0:FRAC_BITS];
    logic [FRAC_BITS+13:0] r_prod;

    logic [OXW-1:0]       pos, diff;
    logic [FRAC_BITS:0]   rel;

    assign pos  = {1'b0, i_raw, {FRAC_BITS{1'b0}}};
    assign diff = pos - i_ox;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= pos <= i_ox;
            r_one[0]  <= (pos > i_ox) && ({1'b0, diff} >= i_sx);
            r_rem[0]  <= {1'b0, diff};
            r_q[0]    <= '0;
        end
    end

    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
        logic [SXW:0] rem2, rsub;
        logic         ge;
        assign rem2 = {r_rem[k-1], 1'b0};
        assign ge   = rem2 >= {1'b0, i_sx};
        assign rsub = rem2 - {1'b0, i_sx};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? rsub[SXW-1:0] : rem2[SXW-1:0];
                r_q[k]    <= {r_q[k-1][FRAC_BITS-2:0], ge};
                r_zero[k] <= r_zero[k-1];
                r_one[k]  <= r_one[k-1];
            end
        end
    end

    always_comb begin
        if (r_zero[FRAC_BITS])     rel = '0;
        else if (r_one[FRAC_BITS]) rel = {1'b1, {FRAC_BITS{1'b0}}};
        else                       rel = {1'b0, r_q[FRAC_BITS]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_prod <= rel * i_vis;
    end

    assign o_mapped = r_prod[FRAC_BITS +: 13];
endmodule

// ===== rtl/letterbox_touch_coordinate_mapper.sv =====
// Top level of the letterbox touch coordinate mapper: registers, setup, two axis pipelines.
// Depends on ltcm_pkg, ltcm_setup, ltcm_axis and the defines header.
//
//  channel   direction  fields (low bit up)
//  s_axis    in         tdata: raw_x[15:0], raw_y[31:16]
//  m_axis    out        tdata: mapped_x[12:0], mapped_y[25:13], zero pad
//  apb       in         eight registers at byte addresses 0, 4, ... 28
//
// One sample enters per cycle unless setup is running or the output stalls; one quotient bit per stage.
// After reset and after every register write the setup sequencer runs nine serial
// operations one after another with s_axis_tready low.
// A stall at the output freezes the whole pipeline; nothing is dropped or repeated.
`include "letterbox_touch_coordinate_mapper_defines.svh"
module letterbox_touch_coordinate_mapper import ltcm_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // raw_x, raw_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // mapped_x, mapped_y, zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int LAT = FRAC_BITS + 2;
    localparam int OXW = 17 + FRAC_BITS;
    localparam int SXW = 18 + FRAC_BITS;

    t_cfg           r_cfg;
    logic [LAT-1:0] r_vld;
    logic           cfg_wr, en, setup_ready;
    logic [OXW-1:0] ox, oy;
    logic [SXW-1:0] sx, sy;
    logic [12:0]    mx, my;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.disp_w <= 13'd800;
            r_cfg.disp_h <= 13'd480;
            r_cfg.vis_w  <= 13'd800;
            r_cfg.vis_h  <= 13'd480;
            r_cfg.nav_t  <= 13'd0;
            r_cfg.nav_e  <= EDGE_BOTTOM;
            r_cfg.tmax_x <= 16'd4095;
            r_cfg.tmax_y <= 16'd4095;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_DISP_W: r_cfg.disp_w <= pwdata[12:0];
                REG_DISP_H: r_cfg.disp_h <= pwdata[12:0];
                REG_VIS_W:  r_cfg.vis_w  <= pwdata[12:0];
                REG_VIS_H:  r_cfg.vis_h  <= pwdata[12:0];
                REG_NAV_T:  r_cfg.nav_t  <= pwdata[12:0];
                REG_NAV_E:  r_cfg.nav_e  <= pwdata[1:0];
                REG_TMAX_X: r_cfg.tmax_x <= pwdata[15:0];
                REG_TMAX_Y: r_cfg.tmax_y <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_DISP_W: prdata = {19'd0, r_cfg.disp_w};
            REG_DISP_H: prdata = {19'd0, r_cfg.disp_h};
            REG_VIS_W:  prdata = {19'd0, r_cfg.vis_w};
            REG_VIS_H:  prdata = {19'd0, r_cfg.vis_h};
            REG_NAV_T:  prdata = {19'd0, r_cfg.nav_t};
            REG_NAV_E:  prdata = {30'd0, r_cfg.nav_e};
            REG_TMAX_X: prdata = {16'd0, r_cfg.tmax_x};
            REG_TMAX_Y: prdata = {16'd0, r_cfg.tmax_y};
            default:    prdata = '0;
        endcase
    end

    ltcm_setup #(.FRAC_BITS(FRAC_BITS)) u_setup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cfg_wr (cfg_wr),
        .o_ready  (setup_ready),
        .o_ox     (ox),
        .o_oy     (oy),
        .o_sx     (sx),
        .o_sy     (sy)
    );

    // The pipeline moves whenever the last stage is empty or being taken.
    assign en            = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = en && setup_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid && s_axis_tready};
        end
    end

    ltcm_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_raw    (s_axis_tdata[15:0]),
        .i_ox     (ox),
        .i_sx     (sx),
        .i_vis    (r_cfg.vis_w),
        .o_mapped (mx)
    );

    ltcm_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_raw    (s_axis_tdata[31:16]),
        .i_ox     (oy),
        .i_sx     (sy),
        .i_vis    (r_cfg.vis_h),
        .o_mapped (my)
    );

    assign m_axis_tvalid = r_vld[LAT-1];
    assign m_axis_tdata  = {6'd0, my, mx};

    `LTCM_ASSERT(a_no_accept_in_setup, !setup_ready, !s_axis_tready)
    `LTCM_ASSERT_NEXT(a_cfg_restarts_setup, cfg_wr, !s_axis_tready)
    `LTCM_ASSERT_NEXT(a_accept_fills_stage, s_axis_tvalid && s_axis_tready, r_vld[0])
endmodule
